// File: rtl/hswc_pkg.sv
package hswc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [12:0] {
        S_LOAD     = 13'b0000000000001,
        S_BLD_RD   = 13'b0000000000010,
        S_BLD_V    = 13'b0000000000100,
        S_SIFT_L   = 13'b0000000001000,
        S_SIFT_R   = 13'b0000000010000,
        S_SIFT_C   = 13'b0000000100000,
        S_SIFT_END = 13'b0000001000000,
        S_EXT_RD0  = 13'b0000010000000,
        S_EXT_RDJ  = 13'b0000100000000,
        S_EXT_W    = 13'b0001000000000,
        S_OUT_RD   = 13'b0010000000000,
        S_OUT_V    = 13'b0100000000000,
        S_OUT_WAIT = 13'b1000000000000
    } t_state;

endpackage

// File: rtl/heap_sort_with_counts_top.sv
// Heapsort with operation counts. Values stream in one per cycle on the slave side (tready
// stays high while loading); up to 64 are kept, later ones are dropped and reported through
// the overflow bit. tlast closes the set and starts an in-place max-heap sort in a 64x32
// single-port-write, registered-read RAM: each sift-down level reads the left child, then the
// right child if there is one, then moves; each heap-build sift first reads its start node,
// each sift ends by writing the sifted value back, and each root extraction reads the root,
// reads the last heap element and writes the root to its place, all paced by the one RAM read.
// Results then leave in ascending order while the master side is ready, each read from the
// RAM only after the previous one is accepted; each carries the saturating comparison and
// exchange counts of the sort, and tlast marks the largest value. No input is taken from the
// closing item until the last result has been accepted.
module heap_sort_with_counts_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hswc_pkg::VAL_W-1:0]       s_tdata,  // [31:0] value
    input  logic                             s_tlast,  // is_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] sorted_value, [51:32] compare_count, [71:52] swap_count, [72] overflow,
    // [79:73] zero
    output logic [hswc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast   // last_of_run
);

    localparam int AW = hswc_pkg::ADDR_W;
    localparam int CW = hswc_pkg::CNT_W;
    localparam int VW = hswc_pkg::VAL_W;
    localparam int KW = hswc_pkg::COUNT_W;

    logic [VW-1:0] mem [hswc_pkg::MAX_ITEMS];
    logic [VW-1:0] r_rdata;

    hswc_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_len, n_len;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_k, n_k;
    logic [VW-1:0] r_val, n_val;
    logic [VW-1:0] r_best_val, n_best_val;
    logic          r_best_left, n_best_left;
    logic [VW-1:0] r_root, n_root;
    logic          r_build, n_build;
    logic [KW-1:0] r_cmp, n_cmp;
    logic [KW-1:0] r_swp, n_swp;
    logic          r_dropped, n_dropped;
    logic          r_out_valid, n_out_valid;
    logic [VW-1:0] r_out_value, n_out_value;
    logic          r_out_last, n_out_last;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [VW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;

    logic [CW:0]   left_idx;
    logic [CW:0]   right_idx;
    logic [CW-1:0] n_last;
    logic          store_ok;
    logic          cmp_inc;
    logic          swp_inc;

    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + (CW+1)'(1);
    assign store_ok  = (r_count < CW'(hswc_pkg::MAX_ITEMS));
    assign n_last    = store_ok ? (r_count + CW'(1)) : CW'(hswc_pkg::MAX_ITEMS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_len       = r_len;
        n_i         = r_i;
        n_pos       = r_pos;
        n_k         = r_k;
        n_val       = r_val;
        n_best_val  = r_best_val;
        n_best_left = r_best_left;
        n_root      = r_root;
        n_build     = r_build;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_wa      = r_pos;
        mem_wd      = r_val;
        mem_ra      = r_i;
        cmp_inc     = 1'b0;
        swp_inc     = 1'b0;

        unique case (r_state)
            hswc_pkg::S_LOAD: begin
                if (s_tvalid) begin
                    if (store_ok) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        mem_wd  = s_tdata;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (s_tlast) begin
                        n_n     = n_last;
                        n_k     = '0;
                        n_build = 1'b1;
                        if (n_last < CW'(2)) begin
                            n_state = hswc_pkg::S_OUT_RD;
                        end else begin
                            n_i     = AW'((n_last >> 1) - CW'(1));
                            n_state = hswc_pkg::S_BLD_RD;
                        end
                    end
                end
            end
            hswc_pkg::S_BLD_RD: begin
                mem_ra  = r_i;
                n_state = hswc_pkg::S_BLD_V;
            end
            hswc_pkg::S_BLD_V: begin
                n_val   = r_rdata;
                n_pos   = r_i;
                n_len   = r_n;
                n_state = hswc_pkg::S_SIFT_L;
            end
            hswc_pkg::S_SIFT_L: begin
                mem_ra = left_idx[AW-1:0];
                if (left_idx < {1'b0, r_len}) begin
                    n_state = hswc_pkg::S_SIFT_R;
                end else begin
                    n_state = hswc_pkg::S_SIFT_END;
                end
            end
            hswc_pkg::S_SIFT_R: begin
                cmp_inc     = 1'b1;
                n_best_left = ($signed(r_rdata) > $signed(r_val));
                n_best_val  = n_best_left ? r_rdata : r_val;
                mem_ra      = right_idx[AW-1:0];
                if (right_idx < {1'b0, r_len}) begin
                    n_state = hswc_pkg::S_SIFT_C;
                end else if (n_best_left) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_pos;
                    mem_wd  = r_rdata;
                    swp_inc = 1'b1;
                    n_pos   = left_idx[AW-1:0];
                    n_state = hswc_pkg::S_SIFT_L;
                end else begin
                    n_state = hswc_pkg::S_SIFT_END;
                end
            end
            hswc_pkg::S_SIFT_C: begin
                cmp_inc = 1'b1;
                if ($signed(r_rdata) > $signed(r_best_val)) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_pos;
                    mem_wd  = r_rdata;
                    swp_inc = 1'b1;
                    n_pos   = right_idx[AW-1:0];
                    n_state = hswc_pkg::S_SIFT_L;
                end else if (r_best_left) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_pos;
                    mem_wd  = r_best_val;
                    swp_inc = 1'b1;
                    n_pos   = left_idx[AW-1:0];
                    n_state = hswc_pkg::S_SIFT_L;
                end else begin
                    n_state = hswc_pkg::S_SIFT_END;
                end
            end
            hswc_pkg::S_SIFT_END: begin
                mem_we = 1'b1;
                mem_wa = r_pos;
                mem_wd = r_val;
                if (r_build) begin
                    if (r_i == '0) begin
                        n_build = 1'b0;
                        n_i     = AW'(r_n - CW'(1));
                        n_state = hswc_pkg::S_EXT_RD0;
                    end else begin
                        n_i     = r_i - AW'(1);
                        n_state = hswc_pkg::S_BLD_RD;
                    end
                end else if (r_i == AW'(1)) begin
                    n_k     = '0;
                    n_state = hswc_pkg::S_OUT_RD;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = hswc_pkg::S_EXT_RD0;
                end
            end
            hswc_pkg::S_EXT_RD0: begin
                mem_ra  = '0;
                n_state = hswc_pkg::S_EXT_RDJ;
            end
            hswc_pkg::S_EXT_RDJ: begin
                n_root  = r_rdata;
                mem_ra  = r_i;
                n_state = hswc_pkg::S_EXT_W;
            end
            hswc_pkg::S_EXT_W: begin
                mem_we  = 1'b1;
                mem_wa  = r_i;
                mem_wd  = r_root;
                swp_inc = 1'b1;
                n_val   = r_rdata;
                n_pos   = '0;
                n_len   = {1'b0, r_i};
                n_state = hswc_pkg::S_SIFT_L;
            end
            hswc_pkg::S_OUT_RD: begin
                mem_ra  = r_k;
                n_state = hswc_pkg::S_OUT_V;
            end
            hswc_pkg::S_OUT_V: begin
                n_out_value = r_rdata;
                n_out_last  = ({1'b0, r_k} == (r_n - CW'(1)));
                n_out_valid = 1'b1;
                n_state     = hswc_pkg::S_OUT_WAIT;
            end
            hswc_pkg::S_OUT_WAIT: begin
                if (m_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = hswc_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = hswc_pkg::S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = hswc_pkg::S_LOAD;
            end
        endcase

        n_cmp = r_cmp;
        n_swp = r_swp;
        if (cmp_inc && (r_cmp != hswc_pkg::COUNT_MAX)) begin
            n_cmp = r_cmp + KW'(1);
        end
        if (swp_inc && (r_swp != hswc_pkg::COUNT_MAX)) begin
            n_swp = r_swp + KW'(1);
        end
        if ((r_state == hswc_pkg::S_OUT_WAIT) && m_tready && r_out_last) begin
            n_cmp = '0;
            n_swp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hswc_pkg::S_LOAD;
            r_count     <= '0;
            r_cmp       <= '0;
            r_swp       <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_build     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp       <= n_cmp;
            r_swp       <= n_swp;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
            r_build     <= n_build;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_len       <= n_len;
        r_i         <= n_i;
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_val       <= n_val;
        r_best_val  <= n_best_val;
        r_best_left <= n_best_left;
        r_root      <= n_root;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign s_tready = (r_state == hswc_pkg::S_LOAD);
    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out_last;
    assign m_tdata  = {7'b0, r_dropped, r_swp, r_cmp, r_out_value};

    a_load_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hswc_pkg::S_LOAD) |-> !r_out_valid)
        else $error("output item pending while loading");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(hswc_pkg::MAX_ITEMS))
        else $error("element count beyond store depth");

    a_end_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not back to loading after final item");

    a_sift_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == hswc_pkg::S_SIFT_L) || (r_state == hswc_pkg::S_SIFT_R)
            || (r_state == hswc_pkg::S_SIFT_C)) |-> ({1'b0, r_pos} < r_len))
        else $error("sift position outside heap");

endmodule
